// File: rtl/core/aes_encrypt_round_defines.svh
// Assertion macros shared by the round datapath.
// Both expect clk and rst in scope at the point of use.
`ifndef AES_ENCRYPT_ROUND_DEFINES_SVH
`define AES_ENCRYPT_ROUND_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AESR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define AESR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/aesr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aesr_pkg;

  // 16 state bytes, byte 0 in bits 7:0, column-major
  typedef logic [15:0][7:0] block_t;

  localparam logic [7:0] REDUCE_POLY = 8'h1B;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
    8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
    8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
    8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
    8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
    8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
    8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
    8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
    8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
    8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
    8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
    8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
    8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
    8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
    8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
    8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
    8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
    8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
    8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
    8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
    8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
    8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
    8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
    8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
    8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
    8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
    8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
    8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
    8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
    8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
  };

  // multiply by x in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? REDUCE_POLY : 8'h00);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/aesr_sub_shift.sv
`timescale 1ns / 1ps
`default_nettype none

// ShiftRows then SubBytes: row r rotates left by r columns
module aesr_sub_shift (
  input  aesr_pkg::block_t state,
  output aesr_pkg::block_t subbed
);

  for (genvar c = 0; c < 4; c++) begin : g_col
    for (genvar r = 0; r < 4; r++) begin : g_row
      assign subbed[c*4 + r] = aesr_pkg::SBOX[state[((c + r) % 4)*4 + r]];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/aesr_mix_add.sv
`timescale 1ns / 1ps
`default_nettype none

// MixColumns (bypassed on the last round) followed by AddRoundKey
module aesr_mix_add (
  input  aesr_pkg::block_t subbed,
  input  aesr_pkg::block_t key,
  input  logic             is_last,
  output aesr_pkg::block_t result
);

  aesr_pkg::block_t mixed;

  for (genvar c = 0; c < 4; c++) begin : g_col
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] d0, d1, d2, d3;

    assign a0 = subbed[c*4];
    assign a1 = subbed[c*4 + 1];
    assign a2 = subbed[c*4 + 2];
    assign a3 = subbed[c*4 + 3];
    assign d0 = aesr_pkg::xtime(a0);
    assign d1 = aesr_pkg::xtime(a1);
    assign d2 = aesr_pkg::xtime(a2);
    assign d3 = aesr_pkg::xtime(a3);

    assign mixed[c*4]     = d0 ^ d1 ^ a1 ^ a2 ^ a3;
    assign mixed[c*4 + 1] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
    assign mixed[c*4 + 2] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
    assign mixed[c*4 + 3] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
  end

  assign result = (is_last ? subbed : mixed) ^ key;

endmodule

`default_nettype wire

// File: rtl/core/aes_encrypt_round.sv
`timescale 1ns / 1ps
`default_nettype none

// One AES encryption round (aesenc / aesenclast behaviour).
// Input: raise start with the state, round key and is_last on the ports; the
// word is taken at the clock edge where start is high and busy is low.
// busy is high only while rst is held, so outside reset a word can be
// taken on every cycle.
// Output: done is high for exactly one cycle with result_low/result_high.
// The receiver has no back-pressure and must take the word in that cycle.
// Path: the word passes the input register, then the result register; done
// is registered alongside the result word.
// Throughput: one word per cycle, set by the single
// S-box / MixColumns / key-add path between the two registers.
// Reset: synchronous on rst; clears the valid flags so no done is raised
// for words in flight. The data registers are not reset.
// State and key bytes are column-major, byte 0 in bits 7:0 of the low half.
module aes_encrypt_round (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] state_low,
  input  logic [63:0] state_high,
  input  logic [63:0] key_low,
  input  logic [63:0] key_high,
  input  logic        is_last,
  output logic        done,
  output logic [63:0] result_low,
  output logic [63:0] result_high
);

  `include "aes_encrypt_round_defines.svh"

  logic             accept;
  logic             in_valid;
  aesr_pkg::block_t in_state;
  aesr_pkg::block_t in_key;
  logic             in_last;
  aesr_pkg::block_t subbed;
  aesr_pkg::block_t round_out;
  aesr_pkg::block_t res;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= accept;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_state <= {state_high, state_low};
      in_key   <= {key_high, key_low};
      in_last  <= is_last;
    end
    if (in_valid) begin
      res <= round_out;
    end
  end

  aesr_sub_shift u_sub_shift (
    .state  (in_state),
    .subbed (subbed)
  );

  aesr_mix_add u_mix_add (
    .subbed  (subbed),
    .key     (in_key),
    .is_last (in_last),
    .result  (round_out)
  );

  assign result_low  = res[7:0];
  assign result_high = res[15:8];

  `AESR_ASSERT_NEXT(a_accept_flows, accept, in_valid, "accepted word lost before datapath")
  `AESR_ASSERT_NEXT(a_done_follows, in_valid, done, "datapath word gave no done")
  `AESR_ASSERT_NOW(a_done_cause, done, $past(accept, 2), "done without a word taken")

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int         N_RANDOM  = 1200;
  localparam logic [7:0] GF_POLY   = 8'h1B;  // x^8 + x^4 + x^3 + x + 1
  localparam logic [7:0] AFFINE_C  = 8'h63;
  localparam int         DRAIN_CYC = 8;

  typedef struct packed {
    logic [63:0] state_low;
    logic [63:0] state_high;
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic        is_last;
  } round_in_t;

  typedef struct packed {
    logic [63:0] low;
    logic [63:0] high;
  } round_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] state_low = '0;
  logic [63:0] state_high = '0;
  logic [63:0] key_low = '0;
  logic [63:0] key_high = '0;
  logic        is_last = 1'b0;
  logic        done;
  logic [63:0] result_low;
  logic [63:0] result_high;

  round_in_t  pending_words[$];
  round_out_t expected_rounds[$];
  int         words_total = 0;
  int         words_taken = 0;
  int         errors = 0;

  aes_encrypt_round dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .state_low  (state_low),
    .state_high (state_high),
    .key_low    (key_low),
    .key_high   (key_high),
    .is_last    (is_last),
    .done       (done),
    .result_low (result_low),
    .result_high(result_high)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p ^= a;
      a = gf_double(a);
      b = b >> 1;
    end
    return p;
  endfunction

  // S-box worked out from first principles: inverse as b^254, then the affine map
  function automatic logic [7:0] sub_byte(input logic [7:0] b);
    logic [7:0] inv;
    logic [7:0] sq;
    inv = 8'h01;
    sq  = b;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) inv = gf_mul(inv, sq);
      sq = gf_mul(sq, sq);
    end
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]} ^
           {inv[3:0], inv[7:4]} ^ AFFINE_C;
  endfunction

  function automatic round_out_t enc_round(input round_in_t w);
    logic [7:0] s[16];
    logic [7:0] k[16];
    logic [7:0] t[16];
    logic [7:0] a0, a1, a2, a3;
    round_out_t res;
    for (int n = 0; n < 8; n++) begin
      s[n]     = w.state_low[8*n +: 8];
      s[n + 8] = w.state_high[8*n +: 8];
      k[n]     = w.key_low[8*n +: 8];
      k[n + 8] = w.key_high[8*n +: 8];
    end
    // row r rotated left by r columns, then substitution
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[c*4 + r] = sub_byte(s[((c + r) % 4)*4 + r]);
    if (!w.is_last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4]; a1 = t[c*4 + 1]; a2 = t[c*4 + 2]; a3 = t[c*4 + 3];
        t[c*4]     = gf_double(a0 ^ a1) ^ a1 ^ a2 ^ a3;
        t[c*4 + 1] = gf_double(a1 ^ a2) ^ a0 ^ a2 ^ a3;
        t[c*4 + 2] = gf_double(a2 ^ a3) ^ a0 ^ a1 ^ a3;
        t[c*4 + 3] = gf_double(a3 ^ a0) ^ a0 ^ a1 ^ a2;
      end
    end
    for (int n = 0; n < 8; n++) begin
      res.low[8*n +: 8]  = t[n] ^ k[n];
      res.high[8*n +: 8] = t[n + 8] ^ k[n + 8];
    end
    return res;
  endfunction

  task automatic queue_word(input logic [63:0] sl, input logic [63:0] sh,
                            input logic [63:0] kl, input logic [63:0] kh,
                            input logic last);
    round_in_t w;
    w = '{state_low: sl, state_high: sh, key_low: kl, key_high: kh, is_last: last};
    pending_words.push_back(w);
    words_total++;
  endtask

  // mostly uniform halves; some built from bytes that hit the awkward S-box inputs
  function automatic logic [63:0] rand_half();
    logic [63:0] v;
    logic [7:0]  picks[6];
    picks = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h53, 8'h7F};
    if ($urandom_range(0, 3) != 0) begin
      v = {$urandom, $urandom};
    end else begin
      for (int n = 0; n < 8; n++)
        v[8*n +: 8] = $urandom_range(0, 1) ? picks[$urandom_range(0, 5)] : 8'($urandom);
    end
    return v;
  endfunction

  // driver
  round_in_t cur;
  round_in_t junk;
  bit        holding = 1'b0;
  bit        calm = 1'b0;
  int        idle_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_rounds.push_back(enc_round(cur));
        words_taken <= words_taken + 1;
        holding = 1'b0;
      end
      if (!holding) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_words.size() != 0) begin
          cur = pending_words.pop_front();
          holding = 1'b1;
          if ($urandom_range(0, 31) == 0) calm = !calm;
          idle_left = calm ? 0 : $urandom_range(0, 8);
        end
      end
      // garbage on the data ports while no word is offered
      junk = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, 1'($urandom)};
      start      <= holding;
      state_low  <= holding ? cur.state_low  : junk.state_low;
      state_high <= holding ? cur.state_high : junk.state_high;
      key_low    <= holding ? cur.key_low    : junk.key_low;
      key_high   <= holding ? cur.key_high   : junk.key_high;
      is_last    <= holding ? cur.is_last    : junk.is_last;
    end
  end

  // monitor
  round_out_t want;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rounds.size() == 0) begin
        $error("unexpected result word: result_low %h result_high %h",
               result_low, result_high);
        errors++;
      end else begin
        want = expected_rounds.pop_front();
        if (result_low !== want.low) begin
          $error("result_low: expected %h, got %h", want.low, result_low);
          errors++;
        end
        if (result_high !== want.high) begin
          $error("result_high: expected %h, got %h", want.high, result_high);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int l = 0; l < 2; l++) begin
      queue_word('0, '0, '0, '0, 1'(l));
      queue_word('1, '1, '1, '1, 1'(l));
      // byte n holds n
      queue_word(64'h0706050403020100, 64'h0F0E0D0C0B0A0908, '0, '0, 1'(l));
      // standard first-round vector
      queue_word(64'h7060504030201000, 64'hF0E0D0C0B0A09080,
                 64'hFA72AFD2FD74AAD6, 64'hFE76ABD6F178A6DA, 1'(l));
      queue_word(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA,
                 64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, 1'(l));
      // top bit set forces the reduction in MixColumns
      queue_word(64'h8080808080808080, 64'h0101010101010101, '0, '1, 1'(l));
      queue_word(64'h5353535353535353, 64'h7F7F7F7F7F7F7F7F,
                 64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 1'(l));
    end
    queue_word('1, '0, '0, '1, 1'b0);
    queue_word('0, '1, '1, '0, 1'b1);
    for (int i = 0; i < N_RANDOM; i++)
      queue_word(rand_half(), rand_half(), rand_half(), rand_half(), 1'($urandom));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (words_taken != words_total) @(posedge clk);
    while (expected_rounds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
